### rtl/gwwlb_pkg.sv
// shared types, constants and helper functions for the word-wrap line breaker
// no dependencies
package gwwlb_pkg;

    localparam int MAX_LINE_CHARS_DEF = 4095;

    localparam int CHAR_W     = 8;
    localparam int WRAP_W     = 16;
    localparam int FONT_W     = 8;
    localparam int PITCH_W    = 8;
    localparam int CHARS_W    = 12;
    localparam int PIX_W      = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_PX    = 1'b1;

    localparam logic [WRAP_W-1:0]  WRAP_RESET  = 16'd320;
    localparam logic [FONT_W-1:0]  FONT_RESET  = 8'd14;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 8'd8;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // floor(x/5) as (x*205)>>10, exact for x below 1024
    localparam logic [10:0] PITCH_RECIP = 11'd205;
    localparam int          PITCH_SHIFT = 10;

    // floor(v/5) as (v*838861)>>22, exact for v below 2**22
    localparam int           PROD_W      = 22;
    localparam logic [19:0]  PIX_RECIP   = 20'd838861;
    localparam int           PIX_SHIFT   = 22;
    localparam logic [PIX_W-1:0]   PIX_MAX   = 20'hFFFFF;
    localparam logic [CHARS_W-1:0] CHARS_MAX = 12'hFFF;

    typedef struct packed {
        logic               valid;
        logic [CHARS_W-1:0] chars;
        logic               eot;
    } rec_t;

    typedef struct packed {
        logic two;
        rec_t first;
        rec_t second;
    } entry_t;

    typedef struct packed {
        logic               valid;
        logic [CHARS_W-1:0] chars;
        logic [PIX_W-1:0]   pixels;
        logic               eot;
    } out_t;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic [PITCH_W-1:0] pitch_of(input logic [FONT_W-1:0] font);
        logic [9:0]  x;
        logic [20:0] p;
        logic [20:0] q;
        x = {2'b00, font} + {1'b0, font, 1'b0};
        p = x * PITCH_RECIP;
        q = p >> PITCH_SHIFT;
        return q[PITCH_W-1:0];
    endfunction

endpackage

### rtl/greedy_word_wrap_line_breaker_top.sv
// greedy fixed-pitch word wrap: one text byte per cycle unless full, results
// one per cycle unless the output queue is empty; a result passes the middle
// queue, the s1 and s2 registers and the output queue before it can be popped;
// a byte that closes two lines becomes two results in the back end
// reset: wrap_width 320, font_px 14, start of line, all queues empty
module greedy_word_wrap_line_breaker_top
    import gwwlb_pkg::*;
#(
    parameter int MAX_LINE_CHARS = MAX_LINE_CHARS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [CHAR_W-1:0]     char_code,
    input  logic                  text_end,
    output logic                  empty,
    input  logic                  pop,
    output logic                  line_valid,
    output logic [CHARS_W-1:0]    line_chars,
    output logic [PIX_W-1:0]      line_pixels,
    output logic                  end_of_text,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [WRAP_W-1:0]  wrap_width_reg;
    logic [FONT_W-1:0]  font_px_reg;
    logic [PITCH_W-1:0] pitch_reg;

    logic   q_push, q_full, q_empty, q_pop;
    entry_t q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_width_reg <= WRAP_RESET;
            font_px_reg    <= FONT_RESET;
            pitch_reg      <= PITCH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WRAP_WIDTH:
                begin
                    wrap_width_reg <= cfg_data[WRAP_W-1:0];
                end
                CFG_FONT_PX:
                begin
                    font_px_reg <= cfg_data[FONT_W-1:0];
                    pitch_reg   <= pitch_of(cfg_data[FONT_W-1:0]);
                end
            endcase
        end
    end

    gwwlb_front #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .char_code  (char_code),
        .text_end   (text_end),
        .full       (full),
        .wrap_width (wrap_width_reg),
        .pitch      (pitch_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    gwwlb_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .count ()
    );

    gwwlb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_rdata),
        .mid_empty   (q_empty),
        .mid_pop     (q_pop),
        .font_px     (font_px_reg),
        .pop         (pop),
        .empty       (empty),
        .line_valid  (line_valid),
        .line_chars  (line_chars),
        .line_pixels (line_pixels),
        .end_of_text (end_of_text)
    );

endmodule

### rtl/gwwlb_fifo.sv
// small register-based word queue with count
// depends on nothing but its parameters
module gwwlb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/gwwlb_front.sv
// front end: takes text bytes, tracks the line state and decides line breaks
// depends on gwwlb_pkg; writes up to two line records per byte into the queue
module gwwlb_front
    import gwwlb_pkg::*;
#(
    parameter int MAX_LINE_CHARS = MAX_LINE_CHARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               text_end,
    output logic               full,
    input  logic [WRAP_W-1:0]  wrap_width,
    input  logic [PITCH_W-1:0] pitch,
    input  logic               q_full,
    output logic               q_push,
    output entry_t             q_data
);

    localparam int CW    = $clog2(MAX_LINE_CHARS+1);
    localparam int PRW   = CW + PITCH_W + 1;
    localparam int CMP_W = (PRW > WRAP_W) ? PRW : WRAP_W;
    localparam int EW    = CW + CHARS_W;

    logic          skip_reg, skip_next;
    logic [CW-1:0] chars_reg, chars_next;
    logic          ss_reg, ss_next;
    logic [CW-1:0] si_reg, si_next;

    logic           accept, ws, nl, wrap;
    logic [CW:0]    ch1;
    logic [PRW-1:0] prod;
    logic [CW-1:0]  carry;
    logic           b_skip, b_ss, take;
    logic [CW-1:0]  b_ch, b_si, t_ch, t_si;
    logic           t_ss;
    logic           e0v;
    logic [CW-1:0]  e0len;
    logic [1:0]     cnt;
    rec_t           ra, rb;

    function automatic logic [CHARS_W-1:0] sat_chars(input logic [CW-1:0] len);
        logic [EW-1:0] ext;
        ext = EW'(len);
        return (ext > EW'(CHARS_MAX)) ? CHARS_MAX : ext[CHARS_W-1:0];
    endfunction

    assign full   = q_full;
    assign accept = push && !q_full;
    assign ws     = is_ws(char_code);
    assign nl     = (char_code == CHAR_NEWLINE);
    assign ch1    = {1'b0, chars_reg} + 1'b1;
    assign prod   = ch1 * pitch;
    assign wrap   = ss_reg && (CMP_W'(prod) > CMP_W'(wrap_width));
    assign carry  = (chars_reg > si_reg) ? chars_reg - si_reg - 1'b1 : '0;

    always_comb
    begin
        b_skip = skip_reg;
        b_ch   = chars_reg;
        b_ss   = ss_reg;
        b_si   = si_reg;
        take   = 1'b0;
        e0v    = 1'b0;
        e0len  = '0;
        if (skip_reg)
        begin
            if (!ws)
            begin
                b_skip = 1'b0;
                b_ch   = '0;
                b_ss   = 1'b0;
                take   = 1'b1;
            end
        end
        else if (nl)
        begin
            e0v    = 1'b1;
            e0len  = chars_reg;
            b_skip = 1'b1;
            b_ch   = '0;
            b_ss   = 1'b0;
            b_si   = '0;
        end
        else if (wrap)
        begin
            e0v   = 1'b1;
            e0len = si_reg;
            b_ch  = carry;
            b_ss  = 1'b0;
            b_si  = '0;
            if (carry == '0 && ws)
            begin
                b_skip = 1'b1;
            end
            else
            begin
                take = 1'b1;
            end
        end
        else
        begin
            take = 1'b1;
        end

        t_ch = (take && (b_ch < CW'(MAX_LINE_CHARS))) ? b_ch + 1'b1 : b_ch;
        t_si = (take && ws) ? b_ch : b_si;
        t_ss = b_ss || (take && ws);

        ra.valid  = e0v;
        ra.chars  = sat_chars(e0len);
        ra.eot    = 1'b0;
        rb.valid  = 1'b1;
        rb.chars  = sat_chars(t_ch);
        rb.eot    = 1'b1;
        cnt       = 2'd0;
        if (e0v)
        begin
            cnt = 2'd1;
            if (text_end)
            begin
                if (!b_skip)
                begin
                    cnt = 2'd2;
                end
                else
                begin
                    ra.eot = 1'b1;
                end
            end
        end
        else if (text_end)
        begin
            cnt = 2'd1;
            if (!b_skip)
            begin
                ra = rb;
            end
            else
            begin
                ra.valid = 1'b0;
                ra.chars = '0;
                ra.eot   = 1'b1;
            end
        end

        q_data.two    = (cnt == 2'd2);
        q_data.first  = ra;
        q_data.second = rb;
        q_push        = accept && (cnt != 2'd0);

        skip_next  = skip_reg;
        chars_next = chars_reg;
        ss_next    = ss_reg;
        si_next    = si_reg;
        if (accept)
        begin
            if (text_end)
            begin
                skip_next  = 1'b1;
                chars_next = '0;
                ss_next    = 1'b0;
                si_next    = '0;
            end
            else
            begin
                skip_next  = b_skip;
                chars_next = t_ch;
                ss_next    = t_ss;
                si_next    = t_si;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg  <= 1'b1;
            chars_reg <= '0;
            ss_reg    <= 1'b0;
            si_reg    <= '0;
        end
        else
        begin
            skip_reg  <= skip_next;
            chars_reg <= chars_next;
            ss_reg    <= ss_next;
            si_reg    <= si_next;
        end
    end

endmodule

### rtl/gwwlb_back.sv
// back end: splits queued records, computes pixel width, buffers results
// depends on gwwlb_pkg and gwwlb_fifo
module gwwlb_back
    import gwwlb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  entry_t             head,
    input  logic               mid_empty,
    output logic               mid_pop,
    input  logic [FONT_W-1:0]  font_px,
    input  logic               pop,
    output logic               empty,
    output logic               line_valid,
    output logic [CHARS_W-1:0] line_chars,
    output logic [PIX_W-1:0]   line_pixels,
    output logic               end_of_text
);

    localparam int OCW = $clog2(OUT_DEPTH+1);
    localparam int BW  = PROD_W + 20;

    logic               sel_reg, sel_next;
    logic               s1_valid_reg;
    rec_t               s1_rec_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic               s2_valid_reg;
    out_t               s2_out_reg;

    logic [OCW-1:0]              out_count;
    logic [OCW+1:0]              busy;
    logic                        issue, last_sub;
    rec_t                        cur;
    logic [CHARS_W+FONT_W-1:0]   m;
    logic [PROD_W-1:0]           prod3;
    logic [BW-1:0]               big, q;
    logic [PIX_W-1:0]            pix;
    out_t                        rd;

    assign busy     = (OCW+2)'(out_count) + (OCW+2)'(s1_valid_reg)
                    + (OCW+2)'(s2_valid_reg);
    assign issue    = !mid_empty && (busy < (OCW+2)'(OUT_DEPTH));
    assign cur      = sel_reg ? head.second : head.first;
    assign last_sub = !head.two || sel_reg;
    assign mid_pop  = issue && last_sub;
    assign sel_next = issue ? !last_sub : sel_reg;

    assign m     = cur.chars * font_px;
    assign prod3 = PROD_W'({m, 1'b0}) + PROD_W'(m);

    assign big = s1_prod_reg * PIX_RECIP;
    assign q   = big >> PIX_SHIFT;
    assign pix = (q > BW'(PIX_MAX)) ? PIX_MAX : q[PIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg      <= sel_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rec_reg        <= cur;
        s1_prod_reg       <= prod3;
        s2_out_reg.valid  <= s1_rec_reg.valid;
        s2_out_reg.chars  <= s1_rec_reg.chars;
        s2_out_reg.eot    <= s1_rec_reg.eot;
        s2_out_reg.pixels <= pix;
    end

    gwwlb_fifo #(
        .WIDTH ($bits(out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s2_valid_reg),
        .wdata (s2_out_reg),
        .full  (),
        .pop   (pop),
        .rdata (rd),
        .empty (empty),
        .count (out_count)
    );

    assign line_valid  = rd.valid;
    assign line_chars  = rd.chars;
    assign line_pixels = rd.pixels;
    assign end_of_text = rd.eot;

endmodule
